FILE: rtl/pte_pkg.sv
package pte_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned APP_PORT_W = 16;
    localparam int unsigned KIND_W     = 4;
    localparam int unsigned ST_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 2'd0,
        OP_CHECK = 2'd1,
        OP_GRANT = 2'd2,
        OP_DENY  = 2'd3
    } opcode_t;

    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [ST_W-1:0] ST_GRANTED = 2'd1;
    localparam logic [ST_W-1:0] ST_DENIED  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch request, rewind scan
        logic scan;    // walk the table
        logic finish;  // update table, load result
    } pte_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_full;
    } pte_sts_t;

endpackage

FILE: rtl/pte_ram.sv
module pte_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pte_ctrl.sv
module pte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pte_pkg::pte_sts_t sts,
    output pte_pkg::pte_cmd_t cmd
);

    pte_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pte_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pte_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pte_pkg::S_SCAN;
                end
            end
            pte_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = pte_pkg::S_FINISH;
                end
            end
            pte_pkg::S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    state_next = pte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pte_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            pte_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            pte_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            pte_pkg::S_FINISH:
            begin
                cmd.finish = !sts.out_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/pte_dp.sv
module pte_dp #(
    parameter int unsigned TABLE_ENTRIES = 512,
    parameter int unsigned APP_ID_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pte_pkg::OP_W-1:0]            opcode,
    input  logic [pte_pkg::APP_PORT_W-1:0]      app_id,
    input  logic [pte_pkg::KIND_W-1:0]          perm_type,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pte_pkg::ST_W-1:0]            status,
    output logic                                granted,
    input  pte_pkg::pte_cmd_t                   cmd,
    output pte_pkg::pte_sts_t                   sts
);

    localparam int unsigned KEY_W =
        (APP_ID_BITS < pte_pkg::APP_PORT_W) ? APP_ID_BITS : pte_pkg::APP_PORT_W;
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned TAG_W = KEY_W + pte_pkg::KIND_W;
    // entry: {app, kind, denied flag}
    localparam int unsigned ENT_W = TAG_W + 1;

    logic [pte_pkg::OP_W-1:0] op_reg;
    logic [TAG_W-1:0]         tag_reg;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             hit_deny_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [pte_pkg::ST_W-1:0] status_reg;
    logic                     granted_reg;

    logic [ENT_W-1:0] rd_data;
    logic             match_now;
    logic             issue;
    logic             room;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;

    logic [pte_pkg::ST_W-1:0] res_status;
    logic                     res_granted;

    pte_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign match_now = pend_reg && (rd_data[ENT_W-1:1] == tag_reg);
    assign issue     = cmd.scan && (scan_idx_reg < used_reg) && !match_now && !hit_reg;
    assign room      = used_reg < CNT_W'(TABLE_ENTRIES);

    assign sts.scan_done = match_now || hit_reg || (scan_idx_reg >= used_reg);
    assign sts.out_full  = out_valid_reg && !out_ready;

    // request latch and hit capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= opcode;
            tag_reg <= {app_id[KEY_W-1:0], perm_type};
        end
        if (pend_reg)
        begin
            hit_idx_reg  <= pend_idx_reg;
            hit_deny_reg <= rd_data[0];
        end
        if (issue)
        begin
            pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        pend_next     = issue;
        hit_next      = hit_reg;
        if (cmd.start)
        begin
            scan_idx_next = '0;
            hit_next      = 1'b0;
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
        if (cmd.scan && match_now)
        begin
            hit_next = 1'b1;
        end
    end

    // result and table update
    always_comb
    begin
        we          = 1'b0;
        waddr       = hit_idx_reg;
        wdata       = {tag_reg, 1'b0};
        used_next   = used_reg;
        res_status  = pte_pkg::ST_UNKNOWN;
        res_granted = 1'b0;
        case (pte_pkg::opcode_t'(op_reg))
            pte_pkg::OP_CHECK:
            begin
                if (hit_reg)
                begin
                    res_status  = hit_deny_reg ? pte_pkg::ST_DENIED : pte_pkg::ST_GRANTED;
                    res_granted = !hit_deny_reg;
                end
            end
            pte_pkg::OP_GRANT:
            begin
                res_granted = 1'b1;
                if (hit_reg)
                begin
                    we = cmd.finish;
                end
                else if (room)
                begin
                    we    = cmd.finish;
                    waddr = used_reg[IDX_W-1:0];
                    if (cmd.finish)
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                end
            end
            pte_pkg::OP_DENY:
            begin
                we    = cmd.finish && hit_reg;
                wdata = {tag_reg, 1'b1};
            end
            default:
            begin
                res_status = pte_pkg::ST_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg  <= res_status;
            granted_reg <= res_granted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign granted   = granted_reg;

endmodule

FILE: rtl/permission_table_engine_top.sv
// A request found at table position k ends its table walk there; a miss walks all
// entries_used filled entries (up to TABLE_ENTRIES).
// Throughput: one request at a time; the linear walk over the table RAM, one entry
// read per cycle through its single read port, sets the rate.
// Reset: rst_n clears the fill count, controller and output valid at once; table
// contents are left as they are, since only filled positions are ever read.
module permission_table_engine_top #(
    parameter int unsigned TABLE_ENTRIES = 512,
    parameter int unsigned APP_ID_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request beat
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pte_pkg::OP_W-1:0]       opcode,
    input  logic [pte_pkg::APP_PORT_W-1:0] app_id,
    input  logic [pte_pkg::KIND_W-1:0]     perm_type,
    // result beat
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pte_pkg::ST_W-1:0]       status,
    output logic                           granted
);

    pte_pkg::pte_cmd_t cmd;
    pte_pkg::pte_sts_t sts;

    // Controller: idle -> scan -> finish. The finish step waits only while an
    // older result beat is still held in the output register, so a new request
    // beat can be taken while the previous result is waiting downstream.
    pte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: table RAM, fill count, scan pointer with a one-deep read
    // pipeline, first-hit capture, and the result register. Grants append at
    // the fill count when nothing matches; a full table drops the append.
    pte_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .APP_ID_BITS   (APP_ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (opcode),
        .app_id    (app_id),
        .perm_type (perm_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .granted   (granted),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
